### hdl/assert_macros.svh
// assertion helpers, empty bodies for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg)

`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

### hdl/phd_pkg.sv
package phd_pkg;

   localparam int COUNT_W  = 24;
   localparam int PITCH_W  = 15;
   localparam int BPS_W    = 5;
   localparam int NBINS_W  = 10;
   localparam int SEL_W    = 9;
   localparam int CENTRE_W = 16;
   localparam int DENS_W   = 17;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PITCH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BPS       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS      = 2'd2;

   localparam logic [PITCH_W-1:0] MIN_PITCH_RESET = 15'd8960;
   localparam logic [BPS_W-1:0]   BPS_RESET       = 5'd5;
   localparam logic [NBINS_W-1:0] BINS_RESET      = 10'd344;
   localparam logic [BPS_W-1:0]   BPS_MAX         = 5'd16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

   // shared divider geometry
   localparam int DIV_NUM_W = 42;
   localparam int DIV_DEN_W = 25;
   localparam int DIV_Q_W   = 18;
   localparam int DIV_CNT_W = 5;

   localparam logic [DIV_Q_W-1:0] CENTRE_LIMIT  = 18'd65535;
   localparam logic [DIV_Q_W-1:0] DENSITY_LIMIT = 18'd65536;

   typedef enum logic [1:0] {
      ACTION_ADD   = 2'd0,
      ACTION_READ  = 2'd1,
      ACTION_CLEAR = 2'd2
   } action_type;

   typedef struct packed {
      logic load_item;
      logic add_calc;
      logic add_read;
      logic add_write;
      logic read_issue;
      logic centre_start;
      logic centre_capture;
      logic dens_start;
      logic dens_capture;
      logic load_rsp;
      logic clear_total;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       div_busy;
      logic       div_done;
      logic       clear_last;
      logic       rsp_free;
   } status_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 24'd1;
   endfunction

endpackage

### hdl/phd_req_if.sv
interface phd_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [phd_pkg::PITCH_W-1:0]  pitch;
   logic [phd_pkg::SEL_W-1:0]    bin_select;

   modport source (output valid, action, pitch, bin_select, input ready);
   modport sink   (input valid, action, pitch, bin_select, output ready);
endinterface

### hdl/phd_rsp_if.sv
interface phd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [phd_pkg::CENTRE_W-1:0]  bin_centre;
   logic [phd_pkg::DENS_W-1:0]    density;
   logic                          empty_res;

   modport source (output valid, bin_centre, density, empty_res, input ready);
   modport sink   (input valid, bin_centre, density, empty_res, output ready);
endinterface

### hdl/phd_divider.sv
module phd_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [phd_pkg::DIV_NUM_W-1:0]   dividend,
   input  logic [phd_pkg::DIV_DEN_W-1:0]   divisor,
   output logic                            busy,
   output logic                            done,
   output logic [phd_pkg::DIV_Q_W-1:0]     quotient
);

   localparam int NW = phd_pkg::DIV_NUM_W;
   localparam int DW = phd_pkg::DIV_DEN_W;
   localparam int QW = phd_pkg::DIV_Q_W;
   localparam logic [phd_pkg::DIV_CNT_W-1:0] LAST_STEP = phd_pkg::DIV_CNT_W'(QW - 1);
   localparam logic [phd_pkg::DIV_CNT_W-1:0] ONE_STEP  = phd_pkg::DIV_CNT_W'(1);

   logic                           busy_ff;
   logic                           done_ff;
   logic [phd_pkg::DIV_CNT_W-1:0]  step_ff;
   logic [DW-1:0]                  rem_ff;
   logic [DW-1:0]                  den_ff;
   logic [QW-1:0]                  work_ff;

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          q_bit;
   logic [DW-1:0] rem_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, work_ff[QW-1]};
      diff   = trial - {1'b0, den_ff};
      q_bit  = (trial >= {1'b0, den_ff});
      rem_in = q_bit ? diff[DW-1:0] : trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + ONE_STEP;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= DW'(dividend[NW-1:QW]);
         work_ff <= dividend[QW-1:0];
         den_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         work_ff <= {work_ff[QW-2:0], q_bit};
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

### hdl/phd_ctrl.sv
module phd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  phd_pkg::status_type  status,
   output phd_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ADD_READ,
      S_ADD_WRITE,
      S_CENTRE_DIV,
      S_DENS_DIV,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.action == phd_pkg::ACTION_ADD) begin
               cmd.add_calc = 1'b1;
               state_in     = S_ADD_READ;
            end else if (status.action == phd_pkg::ACTION_READ) begin
               cmd.read_issue   = 1'b1;
               cmd.centre_start = 1'b1;
               state_in         = S_CENTRE_DIV;
            end else if (status.action == phd_pkg::ACTION_CLEAR) begin
               cmd.clear_total = 1'b1;
               state_in        = S_CLEAR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD_READ: begin
            cmd.add_read = 1'b1;
            state_in     = S_ADD_WRITE;
         end
         S_ADD_WRITE: begin
            cmd.add_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_CENTRE_DIV: begin
            if (status.div_done) begin
               cmd.centre_capture = 1'b1;
               cmd.dens_start     = 1'b1;
               state_in           = S_DENS_DIV;
            end
         end
         S_DENS_DIV: begin
            if (status.div_done) begin
               cmd.dens_capture = 1'b1;
               state_in         = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/phd_datapath.sv
module phd_datapath #(
   parameter int MAX_BINS = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   input  phd_pkg::cmd_type                   cmd,
   output phd_pkg::status_type                status,
   input  logic [1:0]                         req_action,
   input  logic [phd_pkg::PITCH_W-1:0]        req_pitch,
   input  logic [phd_pkg::SEL_W-1:0]          req_bin_select,
   input  logic                               csr_write_en,
   input  logic [phd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [phd_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [phd_pkg::CENTRE_W-1:0]       rsp_bin_centre,
   output logic [phd_pkg::DENS_W-1:0]         rsp_density,
   output logic                               rsp_empty_res
);

   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CW    = phd_pkg::COUNT_W;
   localparam int QW    = phd_pkg::DIV_Q_W;
   localparam int NW    = phd_pkg::DIV_NUM_W;
   localparam int DW    = phd_pkg::DIV_DEN_W;
   localparam logic [13:0]      MAX_BINS_EXT = 14'(MAX_BINS);
   localparam logic [IDX_W-1:0] LAST_ADDR    = IDX_W'(MAX_BINS - 1);
   localparam logic [IDX_W-1:0] ONE_ADDR     = IDX_W'(1);

   // configuration
   logic [phd_pkg::PITCH_W-1:0] min_pitch_ff;
   logic [phd_pkg::BPS_W-1:0]   bps_ff;
   logic [phd_pkg::NBINS_W-1:0] bins_ff;
   logic [phd_pkg::BPS_W-1:0]   bps_eff;

   // current word
   logic [1:0]                  action_ff;
   logic [phd_pkg::PITCH_W-1:0] pitch_ff;
   logic [phd_pkg::SEL_W-1:0]   sel_ff;

   // add path
   logic [15:0]  add_diff;
   logic [19:0]  add_prod;
   logic [11:0]  add_bin;
   logic         add_ok;
   logic [11:0]  bin_ff;
   logic         add_ok_ff;

   // count store
   logic [CW-1:0]    count_mem [MAX_BINS];
   logic [CW-1:0]    rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CW-1:0]    wr_data;
   logic             wr_en;
   logic [IDX_W-1:0] clear_addr_ff;
   logic [CW-1:0]    total_ff;

   // read path
   logic [28:0]      prod_ff;
   logic [NW-1:0]    div_dividend;
   logic [DW-1:0]    div_divisor;
   logic             div_start;
   logic             div_busy;
   logic             div_done;
   logic [QW-1:0]    div_quot;
   logic [QW-1:0]    centre_sum;
   logic             sel_ok;
   logic             empty;
   logic [phd_pkg::CENTRE_W-1:0] centre_ff;
   logic [phd_pkg::DENS_W-1:0]   dens_ff;
   logic                         empty_ff;

   // result register
   logic                         rsp_valid_ff;
   logic [phd_pkg::CENTRE_W-1:0] rsp_centre_ff;
   logic [phd_pkg::DENS_W-1:0]   rsp_dens_ff;
   logic                         rsp_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pitch_ff <= phd_pkg::MIN_PITCH_RESET;
         bps_ff       <= phd_pkg::BPS_RESET;
         bins_ff      <= phd_pkg::BINS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            phd_pkg::CSR_MIN_PITCH: min_pitch_ff <= csr_write_data[phd_pkg::PITCH_W-1:0];
            phd_pkg::CSR_BPS:       bps_ff       <= csr_write_data[phd_pkg::BPS_W-1:0];
            phd_pkg::CSR_BINS:      bins_ff      <= csr_write_data[phd_pkg::NBINS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (bps_ff == '0) begin
         bps_eff = 5'd1;
      end else if (bps_ff > phd_pkg::BPS_MAX) begin
         bps_eff = phd_pkg::BPS_MAX;
      end else begin
         bps_eff = bps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= req_action;
         pitch_ff  <= req_pitch;
         sel_ff    <= req_bin_select;
      end
   end

   // bin = floor((pitch - min) * bps / 256)
   always_comb begin
      add_diff = {1'b0, pitch_ff} - {1'b0, min_pitch_ff};
      add_prod = 20'(add_diff[14:0]) * 20'(bps_eff);
      add_bin  = add_prod[19:8];
      add_ok   = !add_diff[15]
               && (add_bin < {2'b00, bins_ff})
               && ({2'b00, add_bin} < MAX_BINS_EXT);
   end

   always_ff @(posedge clock) begin
      if (cmd.add_calc) begin
         bin_ff    <= add_bin;
         add_ok_ff <= add_ok;
      end
   end

   always_comb begin
      rd_en   = cmd.add_read | cmd.read_issue;
      rd_addr = cmd.add_read ? IDX_W'(bin_ff) : IDX_W'(sel_ff);
      wr_en   = cmd.clear_step | (cmd.add_write & add_ok_ff);
      wr_addr = cmd.clear_step ? clear_addr_ff : IDX_W'(bin_ff);
      wr_data = cmd.clear_step ? '0 : phd_pkg::sat_inc(rd_data_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) count_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= count_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         clear_addr_ff <= '0;
      end else begin
         if (cmd.clear_total) begin
            total_ff      <= '0;
            clear_addr_ff <= '0;
         end else begin
            if (cmd.add_write && add_ok_ff) total_ff <= phd_pkg::sat_inc(total_ff);
            if (cmd.clear_step) clear_addr_ff <= clear_addr_ff + ONE_ADDR;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 29'(rd_data_ff) * 29'(bps_eff);
   end

   // centre offset: ((2*sel+1)*256 + bps) / (2*bps)
   // density: (2*count*bps*4096 + total) / (2*total)
   always_comb begin
      div_start = cmd.centre_start | cmd.dens_start;
      if (cmd.dens_start) begin
         div_dividend = {prod_ff, 13'd0} + NW'(total_ff);
         div_divisor  = {total_ff, 1'b0};
      end else begin
         div_dividend = NW'({sel_ff, 1'b1, 8'd0}) + NW'(bps_eff);
         div_divisor  = DW'({bps_eff, 1'b0});
      end
   end

   phd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      centre_sum = QW'(min_pitch_ff) + div_quot;
      empty      = (total_ff == '0);
      sel_ok     = ({1'b0, sel_ff} < bins_ff) && ({5'd0, sel_ff} < MAX_BINS_EXT);
   end

   always_ff @(posedge clock) begin
      if (cmd.centre_capture) begin
         centre_ff <= (centre_sum > phd_pkg::CENTRE_LIMIT) ? '1 : centre_sum[15:0];
      end
      if (cmd.dens_capture) begin
         empty_ff <= empty;
         if (empty || !sel_ok) begin
            dens_ff <= '0;
         end else if (div_quot > phd_pkg::DENSITY_LIMIT) begin
            dens_ff <= phd_pkg::DENSITY_LIMIT[phd_pkg::DENS_W-1:0];
         end else begin
            dens_ff <= div_quot[phd_pkg::DENS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_centre_ff <= centre_ff;
         rsp_dens_ff   <= dens_ff;
         rsp_empty_ff  <= empty_ff;
      end
   end

   always_comb begin
      status.action     = action_ff;
      status.div_busy   = div_busy;
      status.div_done   = div_done;
      status.clear_last = (clear_addr_ff == LAST_ADDR);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_centre = rsp_centre_ff;
   assign rsp_density    = rsp_dens_ff;
   assign rsp_empty_res  = rsp_empty_ff;

endmodule

### hdl/pitch_histogram_density_unit.sv
// Pitch histogram with density read-back. Each request word is one action: add a
// pitch sample (Q8 semitones) to its bin, read a bin, or clear all counts. An add
// passes through decode and the read-modify-write of the count memory before the
// next ready. A read returns one response word with the bin centre, the Q12 density
// and an empty flag; its time is set by the shared divider, which yields one
// quotient bit per cycle and runs twice (centre offset, then density). A clear
// holds off requests until the count memory has been swept, one entry per cycle,
// and so does the pass after reset; configuration writes are taken at any time.
// Adds and clears give no response. A finished response waits in an output
// register without blocking the next request; a second read that ends while it
// still waits holds until the register is free.
`include "assert_macros.svh"

module pitch_histogram_density_unit #(
   parameter int MAX_BINS = 512
) (
   input  logic                               clock,
   input  logic                               reset,
   phd_req_if.sink                            req_port,
   phd_rsp_if.source                          rsp_port,
   input  logic                               csr_write_en,
   input  logic [phd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [phd_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   phd_pkg::cmd_type    dp_cmd;
   phd_pkg::status_type dp_status;
   logic                req_ready;

   phd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   phd_datapath #(
      .MAX_BINS (MAX_BINS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .req_action     (req_port.action),
      .req_pitch      (req_port.pitch),
      .req_bin_select (req_port.bin_select),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_ready      (rsp_port.ready),
      .rsp_valid      (rsp_port.valid),
      .rsp_bin_centre (rsp_port.bin_centre),
      .rsp_density    (rsp_port.density),
      .rsp_empty_res  (rsp_port.empty_res)
   );

   assign req_port.ready = req_ready;

   `ASSERT_NEXT(a_one_word_at_a_time, clock, reset, req_port.valid && req_ready, !req_ready, "request taken while busy")
   `ASSERT_IMPLY(a_rsp_no_overwrite, clock, reset, dp_cmd.load_rsp, dp_status.rsp_free, "pending response overwritten")
   `ASSERT_IMPLY(a_div_not_restarted, clock, reset, dp_cmd.centre_start || dp_cmd.dens_start, !dp_status.div_busy, "divider restarted while busy")

endmodule

### test/pitch_histogram_density_unit_tb.sv
module pitch_histogram_density_unit_tb;

   localparam int MAX_BINS      = 512;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = MAX_BINS + 40;
   localparam int LONG_HOLD     = 400;
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   typedef struct {
      logic [phd_pkg::CENTRE_W-1:0] centre;
      logic [phd_pkg::DENS_W-1:0]   density;
      logic                         empty;
   } read_word_type;

   class density_scoreboard_type;
      logic [phd_pkg::PITCH_W-1:0] min_pitch;
      logic [phd_pkg::BPS_W-1:0]   bps;
      logic [phd_pkg::NBINS_W-1:0] nbins;
      logic [phd_pkg::COUNT_W-1:0] counts [MAX_BINS];
      logic [phd_pkg::COUNT_W-1:0] total;
      read_word_type               expected_reads [$];
      int                          mismatches;

      function new();
         min_pitch = phd_pkg::MIN_PITCH_RESET;
         bps = phd_pkg::BPS_RESET;
         nbins = phd_pkg::BINS_RESET;
         foreach (counts[i]) counts[i] = '0;
         total = '0;
         mismatches = 0;
      endfunction

      function int unsigned bins_per_semi();
         if (bps == 0) return 1;
         if (bps > phd_pkg::BPS_MAX) return phd_pkg::BPS_MAX;
         return bps;
      endfunction

      function int unsigned bins_counted();
         return (nbins > MAX_BINS) ? MAX_BINS : nbins;
      endfunction

      function void write_reg(logic [phd_pkg::CSR_INDEX_W-1:0] reg_index,
                              logic [phd_pkg::CSR_DATA_W-1:0] data);
         case (reg_index)
            phd_pkg::CSR_MIN_PITCH: min_pitch = data[phd_pkg::PITCH_W-1:0];
            phd_pkg::CSR_BPS:       bps = data[phd_pkg::BPS_W-1:0];
            phd_pkg::CSR_BINS:      nbins = data[phd_pkg::NBINS_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_word(logic [1:0] act, logic [phd_pkg::PITCH_W-1:0] pitch,
                              logic [phd_pkg::SEL_W-1:0] sel);
         int unsigned     semi;
         int unsigned     used;
         int unsigned     diff;
         int unsigned     bin;
         longint unsigned s;
         longint unsigned t;
         longint unsigned offset;
         longint unsigned centre;
         longint unsigned scaled;
         longint unsigned dens;
         read_word_type   r;
         semi = bins_per_semi();
         used = bins_counted();
         case (act)
            phd_pkg::ACTION_ADD: begin
               if (pitch >= min_pitch) begin
                  diff = pitch - min_pitch;
                  bin = (diff * semi) >> 8;
                  if (bin < used) begin
                     if (counts[bin] != phd_pkg::COUNT_MAX) counts[bin] = counts[bin] + 1'b1;
                     if (total != phd_pkg::COUNT_MAX) total = total + 1'b1;
                  end
               end
            end
            phd_pkg::ACTION_READ: begin
               s = sel;
               offset = ((2 * s + 1) * 256 + semi) / (2 * semi);
               centre = min_pitch + offset;
               if (centre > 65535) centre = 65535;
               dens = 0;
               if (total != 0 && sel < used) begin
                  scaled = counts[sel];
                  scaled = scaled * semi * 4096;
                  t = total;
                  dens = (2 * scaled + t) / (2 * t);
                  if (dens > 65536) dens = 65536;
               end
               r.centre = centre[phd_pkg::CENTRE_W-1:0];
               r.density = dens[phd_pkg::DENS_W-1:0];
               r.empty = (total == 0);
               expected_reads = {expected_reads, r};
            end
            phd_pkg::ACTION_CLEAR: begin
               foreach (counts[i]) counts[i] = '0;
               total = '0;
            end
            default: ;
         endcase
      endfunction

      function void check_read(logic [phd_pkg::CENTRE_W-1:0] centre,
                               logic [phd_pkg::DENS_W-1:0] density, logic empty);
         read_word_type want;
         if (expected_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: centre %0d density %0d empty %0b",
                        centre, density, empty);
            return;
         end
         want = expected_reads.pop_front();
         if (centre !== want.centre || density !== want.density || empty !== want.empty) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"read mismatch: centre exp %0d got %0d, density exp %0d got %0d,",
                         " empty exp %0b got %0b"},
                        want.centre, centre, want.density, density, want.empty, empty);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_en;
   logic [phd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [phd_pkg::CSR_DATA_W-1:0]  csr_write_data;
   bit                              idle_enable = 1'b1;
   bit                              long_hold_pending = 1'b0;
   int                              cycle_count = 0;
   density_scoreboard_type          sb = new();

   phd_req_if req_bus();
   phd_rsp_if rsp_bus();

   pitch_histogram_density_unit #(
      .MAX_BINS(MAX_BINS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_read(rsp_bus.bin_centre, rsp_bus.density, rsp_bus.empty_res);
   end

   // response side: random hold-offs, one long hold on request
   initial begin
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [1:0] act, logic [phd_pkg::PITCH_W-1:0] pitch,
                            logic [phd_pkg::SEL_W-1:0] sel);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.pitch <= pitch;
      req_bus.bin_select <= sel;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_word(act, pitch, sel);
   endtask

   // mostly samples inside the bins in use and reads of used bins, some noise
   task automatic send_random(int count);
      int unsigned pick;
      int unsigned semi;
      int unsigned used;
      int unsigned lo;
      int unsigned hi;
      int unsigned pitch;
      int unsigned sel;
      repeat (count) begin
         semi = sb.bins_per_semi();
         used = sb.bins_counted();
         pick = $urandom_range(0, 99);
         if (used == 0 || $urandom_range(0, 4) == 0) begin
            pitch = $urandom_range(0, 32767);
         end else begin
            lo = sb.min_pitch;
            hi = lo + used * 256 / semi;
            if (hi > 32767) hi = 32767;
            pitch = $urandom_range(lo, hi);
         end
         if (used > 0 && $urandom_range(0, 4) != 0) sel = $urandom_range(0, used - 1);
         else sel = $urandom_range(0, 511);
         if (pick < 55) send_word(phd_pkg::ACTION_ADD, 15'(pitch), 9'(sel));
         else if (pick < 92) send_word(phd_pkg::ACTION_READ, 15'(pitch), 9'(sel));
         else if (pick < 96) send_word(ACTION_UNUSED, 15'(pitch), 9'(sel));
         else send_word(phd_pkg::ACTION_CLEAR, 15'(pitch), 9'(sel));
      end
   endtask

   task automatic write_regs(logic [phd_pkg::CSR_DATA_W-1:0] min_edge, per_semi, used_bins);
      logic [phd_pkg::CSR_INDEX_W-1:0] regs [3];
      logic [phd_pkg::CSR_DATA_W-1:0]  values [3];
      regs = '{phd_pkg::CSR_MIN_PITCH, phd_pkg::CSR_BPS, phd_pkg::CSR_BINS};
      values = '{min_edge, per_semi, used_bins};
      for (int i = 0; i < 3; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= regs[i];
         csr_write_data <= values[i];
         @(posedge clock);
         sb.write_reg(regs[i], values[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   // wait for all reads, then for a clear sweep that may still be running
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.expected_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= phd_pkg::CSR_MIN_PITCH;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.action <= phd_pkg::ACTION_ADD;
      req_bus.pitch <= '0;
      req_bus.bin_select <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register values from reset
      send_word(phd_pkg::ACTION_READ, '0, '0);
      send_word(phd_pkg::ACTION_ADD, phd_pkg::MIN_PITCH_RESET, '0);
      send_word(phd_pkg::ACTION_ADD, phd_pkg::MIN_PITCH_RESET - 15'd1, '0);
      send_word(phd_pkg::ACTION_ADD, '0, '0);
      send_word(phd_pkg::ACTION_ADD, 15'h7FFF, '0);
      // first and last pitch of the last bin, then one past it
      send_word(phd_pkg::ACTION_ADD, phd_pkg::MIN_PITCH_RESET + 15'd17562, '0);
      send_word(phd_pkg::ACTION_ADD, phd_pkg::MIN_PITCH_RESET + 15'd17612, '0);
      send_word(phd_pkg::ACTION_ADD, phd_pkg::MIN_PITCH_RESET + 15'd17613, '0);
      send_word(phd_pkg::ACTION_READ, '0, 9'd0);
      send_word(phd_pkg::ACTION_READ, '0, 9'd343);
      send_word(phd_pkg::ACTION_READ, '0, 9'd344);
      send_word(phd_pkg::ACTION_READ, '0, 9'h1FF);
      send_word(ACTION_UNUSED, 15'h7FFF, 9'h1FF);
      send_word(phd_pkg::ACTION_READ, '0, 9'd0);
      send_word(phd_pkg::ACTION_CLEAR, '0, '0);
      send_word(phd_pkg::ACTION_READ, '0, 9'd343);
      send_word(phd_pkg::ACTION_ADD, phd_pkg::MIN_PITCH_RESET + 15'd51, '0);
      send_word(phd_pkg::ACTION_ADD, phd_pkg::MIN_PITCH_RESET + 15'd52, '0);
      send_word(phd_pkg::ACTION_READ, '0, 9'd0);
      send_word(phd_pkg::ACTION_READ, '0, 9'd1);
      send_word(phd_pkg::ACTION_ADD, 15'h2AAA, 9'h155);
      send_word(phd_pkg::ACTION_ADD, 15'h5555, 9'h0AA);
      send_word(phd_pkg::ACTION_READ, 15'h5555, 9'h155);
      send_word(phd_pkg::ACTION_READ, 15'h2AAA, 9'h0AA);

      settle();
      write_regs(15'd0, 15'd1, 15'd512);
      long_hold_pending = 1'b1;
      repeat (20) send_word(phd_pkg::ACTION_READ, 15'($urandom_range(0, 32767)),
                            9'($urandom_range(0, 511)));
      send_random(60);

      settle();
      write_regs(15'h7FFF, 15'd16, 15'd1023);
      send_word(phd_pkg::ACTION_CLEAR, '0, '0);
      send_random(70);

      settle();
      write_regs(15'h7FFF, 15'd0, 15'd1);
      send_random(50);

      settle();
      write_regs(15'($urandom_range(0, 32767)), 15'd31, 15'd0);
      send_random(40);

      settle();
      write_regs(15'($urandom_range(0, 20000)), 15'($urandom_range(1, 16)),
                 15'($urandom_range(1, 512)));
      send_random(80);

      settle();
      write_regs(15'($urandom_range(0, 20000)), 15'($urandom_range(1, 16)),
                 15'($urandom_range(1, 512)));
      idle_enable = 1'b0;
      send_random(80);

      settle();
      if (sb.mismatches == 0 && sb.expected_reads.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/phd_pkg.sv
hdl/phd_req_if.sv
hdl/phd_rsp_if.sv
hdl/phd_divider.sv
hdl/phd_ctrl.sv
hdl/phd_datapath.sv
hdl/pitch_histogram_density_unit.sv
test/pitch_histogram_density_unit_tb.sv
